// ----- sv/signed_decimal_formatter_top_macros.svh -----
// Assertion macros used by the signed decimal formatter sequencer.
`ifndef SIGNED_DECIMAL_FORMATTER_TOP_MACROS_SVH
`define SIGNED_DECIMAL_FORMATTER_TOP_MACROS_SVH

// Both macros sample on i_clk and are disabled while i_rst_n is low.
// The consequent must hold in the same cycle as the antecedent.
`define SDF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sdf_pkg.sv -----
// Types and constants shared by the signed decimal formatter modules.
package sdf_pkg;

    localparam int unsigned DEF_MAX_FIELD = 32;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned NUM_BCD    = 20;
    localparam int unsigned BCD_W      = NUM_BCD * 4;
    localparam int unsigned CONV_STEPS = VALUE_W;
    localparam int unsigned CNT_W      = $clog2(CONV_STEPS);
    localparam int unsigned NAT_W      = $clog2(NUM_BCD + 1);
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PLUS_SIGN   = CFG_IDX_W'(3);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

    typedef enum logic [1:0] {
        OP_IDLE,
        OP_LOAD,
        OP_DABBLE,
        OP_SHIFT
    } t_bcd_op;

    typedef struct packed {
        logic [3:0] top_digit;
        logic       top_zero;
    } t_bcd_status;

    typedef struct packed {
        logic [5:0] field_width;
        logic [4:0] min_digits;
        logic       zero_pad;
        logic       plus_sign;
    } t_fmt_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_DIGITS,
        ST_SIZE,
        ST_EMIT
    } t_state;

endpackage

// ----- sv/signed_decimal_formatter_top.sv -----
// Top level of the signed decimal formatter: configuration registers and unit wiring.
//
// This block turns one signed 64-bit value into the ASCII characters of a
// printf-style signed decimal field, one character per output request, left
// to right, with o_last marking the final character. The magnitude is
// converted to twenty BCD digits by one shared shift-and-add-3 unit; the
// same unit then drops leading zero digits one per cycle and finally shifts
// out one digit per emitted digit character. The input is ready only while
// the sequencer is idle, but the last character may still sit in the output
// register when the next value is accepted. Configuration writes are always
// accepted; they must only be made while no value is in flight. Writes to an
// unknown register index are ignored. A field width above MAX_FIELD is
// treated as MAX_FIELD, and the digit count saturates so the field never
// exceeds MAX_FIELD characters.
module signed_decimal_formatter_top #(
    parameter int unsigned MAX_FIELD = sdf_pkg::DEF_MAX_FIELD
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sdf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sdf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [sdf_pkg::VALUE_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sdf_pkg::CHAR_W-1:0]        o_character,
    output logic                              o_last
);
    import sdf_pkg::*;

    // Configuration registers; all of them clear to zero on reset.
    logic [5:0] r_field_width;
    logic [4:0] r_min_digits;
    logic       r_zero_pad;
    logic       r_plus_sign;

    t_fmt_cfg     cfg;
    t_bcd_op      bcd_op;
    t_bcd_status  bcd_status;

    // The configuration port never stalls a write request.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width <= '0;
            r_min_digits  <= '0;
            r_zero_pad    <= 1'b0;
            r_plus_sign   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FIELD_WIDTH: r_field_width <= i_cfg_data[5:0];
                CFG_MIN_DIGITS:  r_min_digits  <= i_cfg_data[4:0];
                CFG_ZERO_PAD:    r_zero_pad    <= i_cfg_data[0];
                CFG_PLUS_SIGN:   r_plus_sign   <= i_cfg_data[0];
                default: begin
                    r_field_width <= r_field_width;
                end
            endcase
        end
    end

    assign cfg.field_width = r_field_width;
    assign cfg.min_digits  = r_min_digits;
    assign cfg.zero_pad    = r_zero_pad;
    assign cfg.plus_sign   = r_plus_sign;

    // The BCD unit loads the magnitude straight from the input port when the
    // sequencer accepts a request.
    sdf_bcd_unit u_bcd (
        .i_clk    (i_clk),
        .i_op     (bcd_op),
        .i_value  (i_value),
        .o_status (bcd_status)
    );

    sdf_ctrl #(
        .MAX_FIELD (MAX_FIELD)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_neg       (i_value[VALUE_W-1]),
        .o_op        (bcd_op),
        .i_status    (bcd_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

// ----- sv/sdf_bcd_unit.sv -----
// Shared shift-and-add-3 unit holding the magnitude and its BCD digits.
module sdf_bcd_unit (
    input  logic                           i_clk,
    input  sdf_pkg::t_bcd_op               i_op,
    input  logic [sdf_pkg::VALUE_W-1:0]    i_value,
    output sdf_pkg::t_bcd_status           o_status
);
    import sdf_pkg::*;

    logic [VALUE_W-1:0] r_mag;
    logic [VALUE_W-1:0] n_mag;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   n_bcd;
    logic [BCD_W-1:0]   adj;

    // Every digit of five or more gets three added before the next doubling.
    always_comb begin
        for (int d = 0; d < NUM_BCD; d++) begin
            adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= 4'd5) ? (r_bcd[d*4 +: 4] + 4'd3)
                                                       : r_bcd[d*4 +: 4];
        end
    end

    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        case (i_op)
            OP_LOAD: begin
                n_mag = i_value[VALUE_W-1] ? (~i_value + VALUE_W'(1)) : i_value;
                n_bcd = '0;
            end
            OP_DABBLE: begin
                n_bcd = {adj[BCD_W-2:0], r_mag[VALUE_W-1]};
                n_mag = {r_mag[VALUE_W-2:0], 1'b0};
            end
            OP_SHIFT: begin
                n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
            end
            default: begin
                n_mag = r_mag;
                n_bcd = r_bcd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
    end

    assign o_status.top_digit = r_bcd[BCD_W-1 -: 4];
    assign o_status.top_zero  = (r_bcd[BCD_W-1 -: 4] == 4'd0);

endmodule

// ----- sv/sdf_ctrl.sv -----
// Sequencer that drives the BCD unit, sizes the field and emits its characters.
`include "signed_decimal_formatter_top_macros.svh"

module sdf_ctrl #(
    parameter int unsigned MAX_FIELD = sdf_pkg::DEF_MAX_FIELD
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdf_pkg::t_fmt_cfg             i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_neg,
    output sdf_pkg::t_bcd_op              o_op,
    input  sdf_pkg::t_bcd_status          i_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sdf_pkg::CHAR_W-1:0]    o_character,
    output logic                          o_last
);
    import sdf_pkg::*;

    localparam int unsigned W  = $clog2(MAX_FIELD + 1);
    localparam int unsigned CW = ((W > 6) ? W : 6) + 1;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic [NAT_W-1:0]    r_nat, n_nat;
    logic [W-1:0]        r_digits, n_digits;
    logic [W-1:0]        r_size, n_size;
    logic [W-1:0]        r_pos, n_pos;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    logic                sign;
    logic [NAT_W-1:0]    dmax;
    logic [W-1:0]        cap;
    logic [W-1:0]        digits_w;
    logic [W-1:0]        dsum;
    logic [W-1:0]        fw_lim;
    logic [W-1:0]        size_w;
    logic [W-1:0]        digit_start;
    logic [W-1:0]        zero_start;
    logic [W-1:0]        sign_pos;
    logic                is_sign;
    logic                is_digit;
    logic                at_end;
    logic                emit_go;
    logic [CHAR_W-1:0]   emit_char;

    assign sign = r_neg | i_cfg.plus_sign;

    // Digit count: natural count raised to the minimum, capped so the field fits.
    always_comb begin
        dmax     = (NAT_W'(i_cfg.min_digits) > r_nat) ? NAT_W'(i_cfg.min_digits) : r_nat;
        cap      = W'(MAX_FIELD) - W'(sign);
        digits_w = (W'(dmax) > cap) ? cap : W'(dmax);
    end

    always_comb begin
        dsum   = r_digits + W'(sign);
        fw_lim = (CW'(i_cfg.field_width) > CW'(MAX_FIELD)) ? W'(MAX_FIELD)
                                                          : W'(i_cfg.field_width);
        size_w = (fw_lim > dsum) ? fw_lim : dsum;
    end

    // Character at position r_pos of the field.
    always_comb begin
        digit_start = r_size - W'(r_nat);
        zero_start  = r_size - r_digits;
        sign_pos    = i_cfg.zero_pad ? '0 : (zero_start - W'(1));
        is_sign     = sign && (r_pos == sign_pos);
        is_digit    = !is_sign && (r_pos >= digit_start);
        at_end      = (r_pos == r_size - W'(1));
        if (is_sign) begin
            emit_char = r_neg ? CH_MINUS : CH_PLUS;
        end else if (is_digit) begin
            emit_char = CH_ZERO + CHAR_W'(i_status.top_digit);
        end else if (i_cfg.zero_pad || (r_pos >= zero_start)) begin
            emit_char = CH_ZERO;
        end else begin
            emit_char = CH_SPACE;
        end
    end

    assign emit_go = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_nat       = r_nat;
        n_digits    = r_digits;
        n_size      = r_size;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_out_ready;
        n_char      = r_char;
        n_last      = r_last;
        o_op        = OP_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_neg   = i_neg;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                o_op  = OP_DABBLE;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CONV_STEPS - 1)) begin
                    n_nat   = NAT_W'(NUM_BCD);
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                // Drop leading zero digits, keeping at least one.
                if ((r_nat > NAT_W'(1)) && i_status.top_zero) begin
                    o_op  = OP_SHIFT;
                    n_nat = r_nat - NAT_W'(1);
                end else begin
                    n_state = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                n_digits = digits_w;
                n_state  = ST_SIZE;
            end
            ST_SIZE: begin
                n_size  = size_w;
                n_pos   = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_out_valid = 1'b1;
                    n_char      = emit_char;
                    n_last      = at_end;
                    n_pos       = r_pos + W'(1);
                    if (is_digit) begin
                        o_op = OP_SHIFT;
                    end
                    if (at_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_nat    <= n_nat;
        r_digits <= n_digits;
        r_size   <= n_size;
        r_pos    <= n_pos;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    `SDF_ASSERT_NEXT(a_accept_starts_conv, i_in_valid && o_in_ready, (r_state == ST_CONV) && (r_cnt == '0), "accepted request did not start conversion")
    `SDF_ASSERT_IMPL(a_emit_bounds, r_state == ST_EMIT, (r_pos < r_size) && (r_nat != '0) && (r_digits >= W'(r_nat)), "emit position or digit count out of range")
    `SDF_ASSERT_NEXT(a_last_ends_item, (r_state == ST_EMIT) && emit_go && at_end, (r_state == ST_IDLE) && r_out_valid && r_last, "final character did not close the item")

endmodule

// ----- tb/sv/signed_decimal_formatter_top_test.sv -----
// Self-checking testbench for the signed decimal formatter: directed and random values.
`timescale 1ns / 1ps

module signed_decimal_formatter_top_test;

    import sdf_pkg::*;

    localparam int unsigned MAX_FIELD  = DEF_MAX_FIELD;
    localparam int unsigned LIMIT      = 1_000_000;
    // The long output hold-off starts once this many requests have been accepted.
    localparam int unsigned HOLD_AT    = 60;
    localparam int unsigned HOLD_LEN   = 400;
    // Comfortably more than the block needs to finish one value with nothing stalling it.
    localparam int unsigned SETTLE     = 200;
    localparam int unsigned N_PHASES   = 8;
    localparam int unsigned PHASE_ITEMS = 50;

    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

    // One expected character of a formatted field.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char_due;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic signed [VALUE_W-1:0] in_value = '0;
    logic                   out_ready = 1'b0;

    logic                   o_cfg_ready;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [CHAR_W-1:0]      o_character;
    logic                   o_last;

    // Values waiting to be offered, and characters still owed by the block.
    logic [VALUE_W-1:0] values_pending [$];
    t_char_due          chars_due [$];

    // Our copy of the format registers, updated when a register write is accepted.
    t_fmt_cfg fmt = '0;

    int unsigned accepted_cnt = 0;
    int unsigned queued_cnt   = 0;
    int unsigned n_errors     = 0;
    int unsigned cycles       = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;
    // Random idling on both sides; switched off for the final phase.
    logic        idle_en      = 1'b1;

    signed_decimal_formatter_top #(
        .MAX_FIELD(MAX_FIELD)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_value    (in_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_character(o_character),
        .o_last     (o_last)
    );

    always #5 clk = ~clk;

    // Work out the characters of the field for one value under the current format
    // and append them to the characters still owed.
    function automatic void predict_field(logic [VALUE_W-1:0] bits);
        logic [CHAR_W-1:0] text [MAX_FIELD];
        logic              neg;
        logic [63:0]       mag;
        logic [63:0]       t;
        int unsigned       sgn;
        int unsigned       n_nat;
        int unsigned       ndig;
        int unsigned       len;
        int unsigned       lim;
        int unsigned       start;
        int unsigned       i;
        t_char_due         c;

        neg = bits[63];
        mag = neg ? 64'd0 - bits : bits;
        sgn = (neg || fmt.plus_sign) ? 1 : 0;

        // Count the natural digits; zero still has one.
        n_nat = 0;
        t = mag;
        do begin
            n_nat++;
            t = t / 64'd10;
        end while (t != 0);

        ndig = n_nat;
        if (fmt.min_digits > ndig)
            ndig = fmt.min_digits;
        // Digits plus sign never exceed the field limit.
        if (ndig > MAX_FIELD - sgn)
            ndig = MAX_FIELD - sgn;

        len = ndig + sgn;
        lim = (fmt.field_width > MAX_FIELD) ? MAX_FIELD : fmt.field_width;
        if (lim > len)
            len = lim;
        start = len - ndig;

        t = mag;
        for (i = ndig; i > 0; i--) begin
            text[start + i - 1] = CH_ZERO + CHAR_W'(t % 64'd10);
            t = t / 64'd10;
        end
        for (i = 0; i < start; i++)
            text[i] = fmt.zero_pad ? CH_ZERO : CH_SPACE;

        // With zero padding the sign leads the field, otherwise it hugs the digits.
        if (sgn != 0) begin
            if (fmt.zero_pad)
                text[0] = neg ? CH_MINUS : CH_PLUS;
            else
                text[start - 1] = neg ? CH_MINUS : CH_PLUS;
        end

        for (i = 0; i < len; i++) begin
            c.ch   = text[i];
            c.last = (i + 1 == len);
            chars_due.push_back(c);
        end
    endfunction

    function automatic logic [63:0] ten_pow(int unsigned k);
        logic [63:0] p;
        p = 64'd1;
        repeat (k) p = p * 64'd10;
        return p;
    endfunction

    // Random values, weighted toward the cases that change the digit count:
    // small numbers, powers of ten and their neighbors, capped digit counts,
    // and the two ends of the range, with full random words mixed in.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 4))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: v = ten_pow($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
            3: v = {$urandom, $urandom} % ten_pow($urandom_range(1, 19));
            default: v = INT64_MAX - 64'd2 + 64'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 1) == 1)
            v = 64'd0 - v;
        return v;
    endfunction

    // Input driver. A request stays up with the same value until accepted;
    // between requests it may drop valid for a random burst.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_field(in_value);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (in_valid && !o_in_ready) begin
                // The request is still waiting; leave it alone.
            end else if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (values_pending.size() == 0) begin
                in_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 4);
            end else begin
                in_valid <= 1'b1;
                in_value <= values_pending.pop_front();
            end
        end
    end

    // One long hold-off on the output side. While it runs the block cannot hand
    // out its characters, so it stops taking new requests and the sender waits.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && accepted_cnt == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor: every accepted character is checked against the oldest
    // one owed, and ready drops in random bursts.
    always @(posedge clk) begin
        t_char_due exp_c;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (chars_due.size() == 0) begin
                    $display("%0t: character %h with last %b arrived but none was expected",
                             $time, o_character, o_last);
                    n_errors++;
                end else begin
                    exp_c = chars_due.pop_front();
                    if (o_character !== exp_c.ch) begin
                        $display("%0t: character expected %h got %h",
                                 $time, exp_c.ch, o_character);
                        n_errors++;
                    end
                    if (o_last !== exp_c.last) begin
                        $display("%0t: last expected %b got %b", $time, exp_c.last, o_last);
                        n_errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                out_ready  <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog against a block that stops answering.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("signed_decimal_formatter_top: mismatch");
            $finish;
        end
    end

    // Register write request; our copy of the format follows once it is accepted.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FIELD_WIDTH: fmt.field_width = data[5:0];
            CFG_MIN_DIGITS:  fmt.min_digits  = data[4:0];
            CFG_ZERO_PAD:    fmt.zero_pad    = data[0];
            CFG_PLUS_SIGN:   fmt.plus_sign   = data[0];
            default: ;
        endcase
    endtask

    task automatic set_format(logic [CFG_DATA_W-1:0] width, logic [CFG_DATA_W-1:0] mind,
                              logic [CFG_DATA_W-1:0] zpad, logic [CFG_DATA_W-1:0] plus);
        write_reg(CFG_FIELD_WIDTH, width);
        write_reg(CFG_MIN_DIGITS, mind);
        write_reg(CFG_ZERO_PAD, zpad);
        write_reg(CFG_PLUS_SIGN, plus);
    endtask

    task automatic send(logic [63:0] v);
        values_pending.push_back(v);
        queued_cnt++;
    endtask

    // Wait until every queued value has been accepted and every character owed
    // has come out, then wait for the settle time given by settle_cycles.
    task automatic drain(int unsigned settle_cycles);
        do @(posedge clk); while (accepted_cnt != queued_cnt || chars_due.size() != 0);
        repeat (settle_cycles) @(posedge clk);
    endtask

    initial begin
        int unsigned p;
        int unsigned n;

        // Synchronous reset, released once at the start and never applied again.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. First the reset format: zero, plus and minus one and ten,
        // ten to the eighteenth, and the two ends of the signed range.
        send(64'd0);
        send(64'd1);
        send(64'd0 - 64'd1);
        send(64'd10);
        send(64'd0 - 64'd10);
        send(INT64_MAX);
        send(INT64_MIN);
        send(64'd1_000_000_000_000_000_000);
        drain(8);

        // A width of 63 is clamped to the field limit; 31 digits with a sign
        // exactly fill the field limit.
        set_format(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send(64'd0);
        send(INT64_MIN);
        send(64'd42);
        drain(8);

        // Many leading zeros with no plus sign and no width.
        set_format(8'h00, 8'd31, 8'h00, 8'h00);
        send(64'd7);
        send(64'd0 - 64'd7);
        drain(8);

        // Space padding with the sign next to the digits.
        set_format(8'd12, 8'd0, 8'h00, 8'h01);
        send(64'd0);
        send(64'd123);
        send(64'd0 - 64'd123);
        drain(8);

        // Zero padding with the sign in front, plus a minimum digit count.
        set_format(8'd12, 8'd4, 8'h01, 8'h00);
        send(64'd5);
        send(64'd0 - 64'd5);
        send(64'd123_456);
        drain(8);

        // A width just past the field limit, and writes to unknown registers
        // that must leave the format as it is.
        set_format(8'd33, 8'd0, 8'h00, 8'h00);
        write_reg(CFG_IDX_W'(4), 8'hFF);
        write_reg(CFG_IDX_W'(255), 8'h5A);
        send(64'd0 - 64'd1);
        drain(8);

        // Random part: each phase gets its own format. Odd phases use the corner
        // formats, even phases random register data with the high bits exercised.
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                1: set_format(8'd0, 8'd0, 8'h00, 8'h00);
                3: set_format(8'd32, 8'd31, 8'h01, 8'h01);
                5: set_format(8'd40, 8'd20, 8'h00, 8'h01);
                7: set_format(8'd24, 8'd0, 8'h01, 8'h00);
                default: set_format(8'($urandom_range(0, 40)) | 8'($urandom_range(0, 3) << 6),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            write_reg(CFG_IDX_W'($urandom_range(4, 255)), 8'($urandom_range(0, 255)));
            // The last phase runs with no idling on either side.
            if (p == N_PHASES - 1) begin
                @(posedge clk);
                idle_en <= 1'b0;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
                send(pick_value());
            drain(8);
        end

        // Let any stray character show up before the verdict.
        repeat (SETTLE) @(posedge clk);
        if (n_errors == 0) begin
            $display("signed_decimal_formatter_top: match");
        end else begin
            $display("signed_decimal_formatter_top: mismatch");
        end
        $finish;
    end

endmodule
